// File: sv/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg
// Shared constants and types for the cache hit/miss model.
// ----------------------------------------------------------------------------
`default_nettype none
package chm_pkg;
    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int OFFSET_LIMIT   = 10;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_OFFSET = 2'd1,
        CFG_INDEX  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        mode;
        logic [31:0] tag;
        logic [11:0] idx;
        logic [12:0] blocks;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_WRITE,
        ST_DONE,
        ST_CLEAR
    } t_state;
endpackage
`default_nettype wire

// File: sv/cache_hit_miss_model.sv
// ----------------------------------------------------------------------------
// cache_hit_miss_model
// Tag-store model of a direct mapped or fully associative cache.
// ----------------------------------------------------------------------------
// One address per beat in, one hit flag with running totals per beat out.
// After reset the back end clears the valid marks, one entry a cycle,
// before it takes the first lookup. Direct mapped lookups step through
// read, compare and done on a hit, with a write step before done on a miss;
// fully associative lookups scan the tag memory through its single read
// port, a read and a compare step per entry. A finished lookup waits in its last
// step while the output register still holds an unaccepted beat. A two-entry
// queue sits between the classifying front end and the scanning back end.
`default_nettype none
module cache_hit_miss_model #(
    parameter int MAX_BLOCKS = chm_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // address
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // hit, total_accesses, total_hits, pad
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [3:0]  i_cfg_data
);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic r_mode;
    logic [3:0] r_off, r_ib;
    logic jv, jr, busy, hit;
    chm_pkg::t_job job;
    logic [31:0] acc, hc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0; r_off <= 4'd3; r_ib <= 4'd10;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                chm_pkg::CFG_MODE:   r_mode <= i_cfg_data[0];
                chm_pkg::CFG_OFFSET: r_off  <= i_cfg_data;
                chm_pkg::CFG_INDEX:  r_ib   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    chm_front #(.MAX_BLOCKS(MAX_BLOCKS)) u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_address(s_axis_tdata), .i_mode(r_mode), .i_offset_bits(r_off),
        .i_index_bits(r_ib), .o_job_valid(jv), .i_job_ready(jr), .o_job(job));

    chm_back #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW)) u_back (
        .i_clk, .i_rst_n, .i_job_valid(jv), .o_job_ready(jr), .i_job(job),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_hit(hit),
        .o_accesses(acc), .o_hits(hc), .o_busy(busy));

    assign m_axis_tdata = {7'd0, hc, acc, hit};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jv && jr |=> busy) else $error("job taken but back end idle");
    a_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[64:33] != 32'd0)
        else $error("hit with zero hit total");
endmodule
`default_nettype wire

// File: sv/chm_front.sv
// ----------------------------------------------------------------------------
// chm_front
// Classifies an address into tag and index under the current mode and
// pushes a lookup job into a short queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module chm_front #(
    parameter int MAX_BLOCKS = chm_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [31:0]  i_address,
    input  wire logic         i_mode,
    input  wire logic [3:0]   i_offset_bits,
    input  wire logic [3:0]   i_index_bits,
    output logic              o_job_valid,
    input  wire logic         i_job_ready,
    output chm_pkg::t_job     o_job
);
    localparam int MAXIB = $clog2(MAX_BLOCKS + 1) - 1;

    chm_pkg::t_job r_q [chm_pkg::QUEUE_DEPTH];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [3:0]    off, ib;
    logic [31:0]   mask;
    chm_pkg::t_job job;
    logic          push, pop;

    always_comb begin
        off = (i_offset_bits > 4'(chm_pkg::OFFSET_LIMIT)) ?
              4'(chm_pkg::OFFSET_LIMIT) : i_offset_bits;
        ib  = (i_index_bits > 4'(MAXIB)) ? 4'(MAXIB) : i_index_bits;
        mask = (32'd1 << ib) - 32'd1;
        job.mode   = i_mode;
        job.blocks = 13'd1 << ib;
        if (i_mode) begin
            job.tag = i_address >> off;
            job.idx = '0;
        end else begin
            job.tag = i_address >> (5'(off) + 5'(ib));
            job.idx = 12'((i_address >> off) & mask);
        end
    end

    assign o_ready     = (r_cnt != 2'(chm_pkg::QUEUE_DEPTH));
    assign push        = i_valid && o_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign pop         = o_job_valid && i_job_ready;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job;
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// File: sv/chm_back.sv
// ----------------------------------------------------------------------------
// chm_back
// Runs each lookup against the tag memory, one entry at a time, updates the
// entry on a miss and keeps the access and hit totals.
// ----------------------------------------------------------------------------
`default_nettype none
module chm_back #(
    parameter int MAX_BLOCKS = chm_pkg::MAX_BLOCKS_DEF,
    parameter int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_job_valid,
    output logic             o_job_ready,
    input  chm_pkg::t_job    i_job,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_hit,
    output logic [31:0]      o_accesses,
    output logic [31:0]      o_hits,
    output logic             o_busy
);
    logic [31:0]   r_mem [MAX_BLOCKS];
    logic          r_vld [MAX_BLOCKS];
    logic [31:0]   r_rd;
    logic          r_rdv;
    chm_pkg::t_state r_st, n_st;
    chm_pkg::t_job r_job;
    logic [12:0]   r_i;
    logic [IW-1:0] r_vp, r_empty, r_wa;
    logic          r_have_e, r_hit;
    logic [31:0]   r_acc, r_hc;
    logic          r_ov, r_oh;
    logic [31:0]   r_oa, r_ohc;
    logic [IW-1:0] ci, vpm;
    logic          last, match;

    assign ci    = IW'(r_job.mode ? r_i : 13'(r_job.idx));
    assign match = r_rdv && (r_rd == r_job.tag);
    assign last  = !r_job.mode || (r_i + 13'd1 == r_job.blocks);
    assign vpm   = IW'(13'(r_vp) & (r_job.blocks - 13'd1));

    always_comb begin
        n_st = r_st;
        case (r_st)
            chm_pkg::ST_CLEAR: if (r_i == 13'(MAX_BLOCKS - 1)) n_st = chm_pkg::ST_IDLE;
            chm_pkg::ST_IDLE:  if (i_job_valid) n_st = chm_pkg::ST_READ;
            chm_pkg::ST_READ:  n_st = chm_pkg::ST_CMP;
            chm_pkg::ST_CMP: begin
                if (match) n_st = chm_pkg::ST_DONE;
                else if (last) n_st = chm_pkg::ST_WRITE;
                else n_st = chm_pkg::ST_READ;
            end
            chm_pkg::ST_WRITE: n_st = chm_pkg::ST_DONE;
            chm_pkg::ST_DONE:  if (!r_ov || i_ready) n_st = chm_pkg::ST_IDLE;
            default:           n_st = chm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = (r_st == chm_pkg::ST_IDLE);
        o_busy      = (r_st != chm_pkg::ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (r_st == chm_pkg::ST_READ) begin
            r_rd  <= r_mem[ci];
        end
        if (r_st == chm_pkg::ST_WRITE) r_mem[r_wa] <= r_job.tag;
        if (r_st == chm_pkg::ST_CLEAR) r_vld[IW'(r_i)] <= 1'b0;
        else if (r_st == chm_pkg::ST_WRITE) r_vld[r_wa] <= 1'b1;
        if (r_st == chm_pkg::ST_IDLE && i_job_valid) r_job <= i_job;
        if (!i_rst_n) begin
            r_st <= chm_pkg::ST_CLEAR;
            r_vp <= '0; r_acc <= '0; r_hc <= '0; r_ov <= 1'b0;
            r_i <= '0; r_have_e <= 1'b0; r_hit <= 1'b0; r_rdv <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_valid && i_ready && r_st != chm_pkg::ST_DONE) r_ov <= 1'b0;
            case (r_st)
                chm_pkg::ST_CLEAR: r_i <= r_i + 13'd1;
                chm_pkg::ST_IDLE: begin
                    r_i <= '0; r_have_e <= 1'b0; r_hit <= 1'b0;
                end
                chm_pkg::ST_READ: r_rdv <= r_vld[ci];
                chm_pkg::ST_CMP: begin
                    if (match) r_hit <= 1'b1;
                    else begin
                        if (!r_rdv && !r_have_e) begin
                            r_have_e <= 1'b1;
                            r_empty  <= ci;
                        end
                        r_i <= r_i + 13'd1;
                        if (last) begin
                            if (!r_job.mode) r_wa <= ci;
                            else if (!r_rdv && !r_have_e) r_wa <= ci;
                            else if (r_have_e) r_wa <= r_empty;
                            else begin
                                r_wa <= vpm;
                                r_vp <= IW'((13'(vpm) + 13'd1) & (r_job.blocks - 13'd1));
                            end
                        end
                    end
                end
                chm_pkg::ST_DONE: if (!r_ov || i_ready) begin
                    r_ov  <= 1'b1;
                    r_oh  <= r_hit;
                    r_oa  <= r_acc + 32'd1;
                    r_ohc <= r_hc + 32'(r_hit);
                    r_acc <= r_acc + 32'd1;
                    r_hc  <= r_hc + 32'(r_hit);
                end
                default: ;
            endcase
        end
    end

    assign o_valid    = r_ov;
    assign o_hit      = r_oh;
    assign o_accesses = r_oa;
    assign o_hits     = r_ohc;
endmodule
`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - cache hit/miss model testbench
// Streams addresses into the tag-store model under a series of mapping,
// offset and index settings, predicts hit and running totals for every
// accepted beat, and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // address
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;         // hit, total_accesses, total_hits, pad
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [3:0]  i_cfg_data = '0;

    typedef struct {
        bit        hit;
        bit [31:0] accesses;
        bit [31:0] hits;
    } t_lookup;

    bit [31:0]   addr_q[$];
    bit [31:0]   recent_q[$];
    t_lookup     lookup_q[$];

    bit [31:0]   tags[1024];
    bit          valid[1024];
    bit [9:0]    victim;
    bit [31:0]   acc_cnt;
    bit [31:0]   hit_cnt;
    bit          cfg_mode;
    bit [3:0]    cfg_offset;
    bit [3:0]    cfg_index;

    int          errors;
    int          beats_out;
    int          hits_seen;
    int          phases;
    bit          no_idle;
    int          rx_freeze;

    cache_hit_miss_model i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void predict_lookup(bit [31:0] addr);
        int      eo;
        int      ei;
        int      blocks;
        bit [31:0] mask;
        bit [31:0] ix;
        bit [31:0] tg;
        bit      hit;
        bit      have_empty;
        int      empty;
        t_lookup r;
        eo = (cfg_offset > 10) ? 10 : cfg_offset;
        ei = (cfg_index > 10) ? 10 : cfg_index;
        blocks = 1 << ei;
        mask = blocks - 1;
        hit = 1'b0;
        have_empty = 1'b0;
        empty = 0;
        if (!cfg_mode) begin
            ix = (addr >> eo) & mask;
            tg = addr >> (eo + ei);
            if (valid[ix] && tags[ix] == tg) begin
                hit = 1'b1;
            end else begin
                tags[ix] = tg;
                valid[ix] = 1'b1;
            end
        end else begin
            tg = addr >> eo;
            for (int i = 0; i < blocks; i++) begin
                if (valid[i]) begin
                    if (tags[i] == tg) begin
                        hit = 1'b1;
                        break;
                    end
                end else if (!have_empty) begin
                    have_empty = 1'b1;
                    empty = i;
                end
            end
            if (!hit) begin
                if (have_empty) begin
                    tags[empty] = tg;
                    valid[empty] = 1'b1;
                end else begin
                    ix = victim & mask;
                    tags[ix] = tg;
                    valid[ix] = 1'b1;
                    victim = (ix + 1) & mask;
                end
            end
        end
        acc_cnt = acc_cnt + 1;
        if (hit) hit_cnt = hit_cnt + 1;
        r.hit = hit;
        r.accesses = acc_cnt;
        r.hits = hit_cnt;
        lookup_q.push_back(r);
    endfunction

    task automatic report(string what, bit [31:0] got, bit [31:0] want);
        $display("MISMATCH beat %0d %s: got %h want %h", beats_out, what, got, want);
        errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_lookup(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (addr_q.size() > 0 && (no_idle || $urandom_range(99) >= 26)) begin
                    s_axis_tdata  <= addr_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_lookup w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (lookup_q.size() == 0) begin
                    report("unexpected beat", m_axis_tdata[31:0], 32'h0);
                end else begin
                    w = lookup_q.pop_front();
                    if (m_axis_tdata[0] !== w.hit) report("hit", m_axis_tdata[0], w.hit);
                    if (m_axis_tdata[32:1] !== w.accesses)
                        report("total_accesses", m_axis_tdata[32:1], w.accesses);
                    if (m_axis_tdata[64:33] !== w.hits)
                        report("total_hits", m_axis_tdata[64:33], w.hits);
                    if (w.hit) hits_seen++;
                end
                beats_out++;
            end
            if (rx_freeze > 0) begin
                rx_freeze <= rx_freeze - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(99) >= 26);
            end
        end
    end

    task automatic cfg_write(chm_pkg::t_cfg_idx idx, bit [3:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            chm_pkg::CFG_MODE:   cfg_mode = val[0];
            chm_pkg::CFG_OFFSET: cfg_offset = val;
            chm_pkg::CFG_INDEX:  cfg_index = val;
            default: ;
        endcase
    endtask

    task automatic set_cfg(bit mode, bit [3:0] off, bit [3:0] ix);
        cfg_write(chm_pkg::CFG_MODE, {3'b000, mode});
        cfg_write(chm_pkg::CFG_OFFSET, off);
        cfg_write(chm_pkg::CFG_INDEX, ix);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (addr_q.size() > 0 || s_axis_tvalid || lookup_q.size() > 0);
        repeat (20) @(posedge i_clk);
        phases++;
    endtask

    task automatic random_phase(int n);
        bit [31:0] a;
        recent_q.delete();
        for (int k = 0; k < n; k++) begin
            if (recent_q.size() > 0 && $urandom_range(99) < 55) begin
                a = recent_q[$urandom_range(recent_q.size() - 1)] ^ ($urandom & 32'h3f);
            end else begin
                a = $urandom;
            end
            recent_q.push_back(a);
            if (recent_q.size() > 12) void'(recent_q.pop_front());
            addr_q.push_back(a);
        end
        wait_drained();
    endtask

    initial begin
        cfg_mode = 1'b0;
        cfg_offset = 4'd3;
        cfg_index = 4'd10;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // default setting: extremes, same-block hit, conflict eviction
        addr_q = '{32'h0, 32'hffffffff, 32'h0, 32'hffffffff, 32'h8, 32'h7,
                   32'h2000, 32'h0, 32'h2000, 32'h80000000};
        wait_drained();
        set_cfg(1'b0, 4'd0, 4'd0);
        addr_q = '{32'h0, 32'h1, 32'h1, 32'hffffffff, 32'hffffffff, 32'h7fffffff};
        wait_drained();
        // oversize offset and index saturate
        set_cfg(1'b0, 4'd15, 4'd15);
        random_phase(60);
        set_cfg(1'b0, 4'd4, 4'd5);
        no_idle = 1'b1;
        random_phase(70);
        no_idle = 1'b0;
        // mode change without flush; hold the receiver off to back up the input
        set_cfg(1'b1, 4'd2, 4'd3);
        rx_freeze = 400;
        random_phase(80);
        // shrink index so the victim pointer wraps into range
        set_cfg(1'b1, 4'd2, 4'd2);
        random_phase(40);
        set_cfg(1'b1, 4'd10, 4'd10);
        random_phase(20);
        set_cfg(1'b0, 4'd3, 4'd10);
        random_phase(40);
        set_cfg(1'b1, 4'd0, 4'd4);
        random_phase(80);
        set_cfg(1'b1, 4'd15, 4'd0);
        random_phase(20);
        set_cfg(1'b0, 4'd1, 4'd1);
        random_phase(124);

        $display("Covered %0d phases over both mappings, %0d result beats, %0d hits.",
                 phases, beats_out, hits_seen);
        $display("Settings included zero and saturating offset/index, FIFO refill and wrap.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout waiting for results");
        $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
